[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, muted in reset
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication, muted in reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[rtl/ogid_pkg.sv]
// shared types and codes for the occupancy grid inflate and despeckle block
// no dependencies
package ogid_pkg;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_PROCESS = 2'd2;
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;
   localparam logic [7:0] OBSTACLE_VAL = 8'd100;
   localparam logic [7:0] INFLATED_VAL = 8'd99;
   localparam logic CSR_RADIUS = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_RDWAIT  = 9'b000000010,
      ST_IC_RD   = 9'b000000100,
      ST_IC_CHK  = 9'b000001000,
      ST_IN_RD   = 9'b000010000,
      ST_IN_WR   = 9'b000100000,
      ST_DC_RD   = 9'b001000000,
      ST_DN_RD   = 9'b010000000,
      ST_DC_WR   = 9'b100000000
   } state_type;
endpackage

[rtl/occupancy_grid_inflate_and_despeckle.sv]
// Occupancy grid block: cell writes and reads over req_, one response per read or process
// request. A process request walks the grid on the single cell memory port: every cell is
// read; each inflating obstacle then reads its (2*INFLATE_REACH+1)^2 neighbourhood and
// rewrites each in-grid cell that is not an obstacle, skipping offsets off the grid, and in
// a second pass each cell in 1..98 reads its (2*FILTER_REACH+1)^2 window the same way plus
// one write slot. The cell store has no reset and must be loaded before use.
module occupancy_grid_inflate_and_despeckle #(
   parameter int GRID_WIDTH = 128,
   parameter int GRID_HEIGHT = 128,
   parameter int INFLATE_REACH = 2,
   parameter int FILTER_REACH = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // cmd[1:0], cell_index[15:2], cell_value[23:16], full_inflate[24]
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [13:0] csr_wr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // read_value[7:0]
   output logic        rsp_tuser   // result_kind
);
   import ogid_pkg::*;
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(GRID_WIDTH);
   localparam int RW = $clog2(GRID_HEIGHT);
   localparam int SW = 12;
   localparam int CX = GRID_WIDTH / 2;
   localparam int CY = GRID_HEIGHT / 2;

   state_type st_ff, st_in;
   logic [13:0] rad_ff, rad_in;
   logic [5:0] thr_ff, thr_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic signed [SW-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [6:0] zc_ff, zc_in;
   logic full_ff, full_in;
   logic despk_ff, despk_in;
   logic rv_ff, rv_in;
   logic [7:0] rd_ff, rd_in;
   logic rk_ff, rk_in;
   logic we;
   logic [AW-1:0] addr;
   logic [7:0] wdata, q;

   logic [1:0] cmd;
   logic [13:0] idx;
   assign cmd = req_tdata[1:0];
   assign idx = req_tdata[15:2];

   logic signed [SW-1:0] nr, nc, reach;
   logic inb, last_off, last_cell;
   logic signed [SW-1:0] dx, dy;
   logic [23:0] dsq;
   logic signed [23:0] mx, my;

   assign reach = despk_ff ? SW'(FILTER_REACH) : SW'(INFLATE_REACH);
   assign nr = $signed(SW'(r_ff)) + dr_ff;
   assign nc = $signed(SW'(c_ff)) + dc_ff;
   assign inb = nr >= 0 && nr < SW'(GRID_HEIGHT) && nc >= 0 && nc < SW'(GRID_WIDTH);
   assign last_off = dr_ff == reach && dc_ff == reach;
   assign last_cell = r_ff == RW'(GRID_HEIGHT - 1) && c_ff == CW'(GRID_WIDTH - 1);
   assign dx = $signed(SW'(c_ff)) - SW'(CX);
   assign dy = $signed(SW'(r_ff)) - SW'(CY);
   assign mx = 24'(dx) * 24'(dx);
   assign my = 24'(dy) * 24'(dy);
   assign dsq = 24'(mx) + 24'(my);

   assign req_tready = st_ff == ST_IDLE && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tuser = rk_ff;

   ogid_grid_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(q));

   always_comb begin
      st_in = st_ff; rad_in = rad_ff; thr_in = thr_ff;
      r_in = r_ff; c_in = c_ff; dr_in = dr_ff; dc_in = dc_ff; zc_in = zc_ff;
      full_in = full_ff; despk_in = despk_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff; rk_in = rk_ff;
      we = 1'b0; wdata = req_tdata[23:16];
      addr = AW'(32'(r_ff) * GRID_WIDTH + 32'(c_ff));
      if (csr_wr_en) begin
         if (csr_index == CSR_RADIUS) rad_in = csr_wr_data;
         else thr_in = csr_wr_data[5:0];
      end
      unique case (st_ff)
         ST_IDLE: begin
            addr = AW'(idx);
            if (req_tvalid && req_tready) begin
               unique case (cmd)
                  CMD_WRITE: we = 32'(idx) < CELLS;
                  CMD_READ: begin
                     if (32'(idx) < CELLS) st_in = ST_RDWAIT;
                     else begin rv_in = 1'b1; rd_in = 8'd0; rk_in = KIND_READ; end
                  end
                  CMD_PROCESS: begin
                     full_in = req_tdata[24]; despk_in = 1'b0;
                     r_in = '0; c_in = '0; st_in = ST_IC_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RDWAIT: begin
            rv_in = 1'b1; rd_in = q; rk_in = KIND_READ; st_in = ST_IDLE;
         end
         ST_IC_RD: st_in = despk_ff ? ST_DC_RD : ST_IC_CHK;
         ST_IC_CHK, ST_DC_RD: begin
            dr_in = -reach; dc_in = -reach; zc_in = '0;
            if (!despk_ff && q == OBSTACLE_VAL && (full_ff || dsq > 24'(rad_ff)))
               st_in = ST_IN_RD;
            else if (despk_ff && $signed(q) >= 1 && $signed(q) <= 98)
               st_in = ST_DN_RD;
            else st_in = ST_IN_WR;
            if (st_in == ST_IN_WR) begin
               // advance to next cell
               st_in = ST_IC_RD;
               if (c_ff == CW'(GRID_WIDTH - 1)) begin c_in = '0; r_in = r_ff + 1'b1; end
               else c_in = c_ff + 1'b1;
               if (last_cell) begin
                  r_in = '0; c_in = '0;
                  if (despk_ff) begin
                     st_in = ST_IDLE; rv_in = 1'b1; rd_in = 8'd0; rk_in = KIND_DONE;
                  end else despk_in = 1'b1;
               end
            end
         end
         ST_IN_RD, ST_DN_RD: begin
            addr = AW'(32'(nr) * GRID_WIDTH + 32'(nc));
            if (inb) st_in = ST_IN_WR;
            else begin
               st_in = st_ff;
               if (dc_ff == reach) begin dc_in = -reach; dr_in = dr_ff + 1'b1; end
               else dc_in = dc_ff + 1'b1;
               if (last_off) st_in = despk_ff ? ST_DC_WR : ST_IC_RD;
               if (last_off && !despk_ff) st_in = ST_IN_WR;
            end
            if (st_in == ST_IN_WR && !inb) begin
               // last offset out of grid: step to next cell via a no-op write slot
               dr_in = reach + 1'b1;
            end
            if (st_in == ST_IN_WR) despk_in = despk_ff;
         end
         ST_IN_WR: begin
            addr = AW'(32'(nr) * GRID_WIDTH + 32'(nc));
            if (despk_ff) begin
               if (dr_ff <= reach && q == 8'd0) zc_in = zc_ff + 1'b1;
            end else begin
               wdata = INFLATED_VAL;
               we = dr_ff <= reach && q != OBSTACLE_VAL;
            end
            if (dr_ff > reach || last_off) begin
               if (despk_ff) st_in = ST_DC_WR;
               else begin
                  st_in = ST_IC_RD;
                  if (c_ff == CW'(GRID_WIDTH - 1)) begin c_in = '0; r_in = r_ff + 1'b1; end
                  else c_in = c_ff + 1'b1;
                  if (last_cell) begin r_in = '0; c_in = '0; despk_in = 1'b1; end
               end
               if (despk_ff && dr_ff <= reach && q == 8'd0) zc_in = zc_ff + 1'b1;
            end else begin
               if (dc_ff == reach) begin dc_in = -reach; dr_in = dr_ff + 1'b1; end
               else dc_in = dc_ff + 1'b1;
               st_in = despk_ff ? ST_DN_RD : ST_IN_RD;
            end
         end
         ST_DC_WR: begin
            wdata = 8'd0;
            we = {1'b0, zc_ff} > {1'b0, thr_ff};
            st_in = ST_IC_RD;
            if (c_ff == CW'(GRID_WIDTH - 1)) begin c_in = '0; r_in = r_ff + 1'b1; end
            else c_in = c_ff + 1'b1;
            if (last_cell) begin
               r_in = '0; c_in = '0; st_in = ST_IDLE;
               rv_in = 1'b1; rd_in = 8'd0; rk_in = KIND_DONE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rv_ff <= 1'b0; rad_ff <= 14'd1600; thr_ff <= 6'd35;
         despk_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in; rad_ff <= rad_in; thr_ff <= thr_in;
         despk_ff <= despk_in;
      end
      r_ff <= r_in; c_ff <= c_in; dr_ff <= dr_in; dc_ff <= dc_in; zc_ff <= zc_in;
      full_ff <= full_in; rd_ff <= rd_in; rk_ff <= rk_in;
   end
endmodule

[rtl/ogid_grid_ram.sv]
// single-port occupancy cell store, registered read
// depends on nothing
module ogid_grid_ram #(
   parameter int DEPTH = 16384,
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[rtl/ogid_checker.sv]
// port-level checks for the occupancy grid block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ogid_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);
   `ASSERT_IMPLY(a_busy, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLY(a_done_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 8'd0)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind occupancy_grid_inflate_and_despeckle ogid_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser));

[verif/occupancy_grid_inflate_and_despeckle_tb.sv]
// self-checking testbench for occupancy_grid_inflate_and_despeckle: loads the grid,
// runs a directed table then random requests, and checks responses against a grid predictor
// depends on rtl/ogid_pkg.sv and rtl/occupancy_grid_inflate_and_despeckle.sv
`timescale 1ns / 100ps
`default_nettype none

module occupancy_grid_inflate_and_despeckle_tb;
   import ogid_pkg::*;

   localparam int GW = 128;
   localparam int GH = 128;
   localparam int NCELLS = GW * GH;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
   } grid_rsp_t;

   typedef struct {
      logic [1:0]  cmd;
      logic [13:0] idx;
      logic [7:0]  val;
      logic        full;
      bit          typed;
      grid_rsp_t   rsp;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // cmd, cell_index, cell_value, full_inflate
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [13:0] csr_wr_data = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;  // read_value
   logic        rsp_tuser;  // result_kind

   logic signed [7:0] grid_cells [0:NCELLS-1];
   int unsigned radius_sq = 1600;
   int unsigned clear_limit = 35;
   grid_rsp_t   pending_rsp [$];
   int          mismatches = 0;
   int unsigned cycles = 0;
   int          sender_idle = 15;
   int          rx_idle = 78;

   occupancy_grid_inflate_and_despeckle dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic void inflate_obstacles(bit full);
      int dx, dy, nr, nc;
      for (int r = 0; r < GH; r++) begin
         for (int c = 0; c < GW; c++) begin
            if (grid_cells[r*GW+c] != 8'sd100) continue;
            dx = c - GW/2;
            dy = r - GH/2;
            if (!full && (dx*dx + dy*dy) <= int'(radius_sq)) continue;
            for (int dr = -2; dr <= 2; dr++) begin
               for (int dc = -2; dc <= 2; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if (nr < 0 || nr >= GH || nc < 0 || nc >= GW) continue;
                  if (grid_cells[nr*GW+nc] != 8'sd100) grid_cells[nr*GW+nc] = INFLATED_VAL;
               end
            end
         end
      end
   endfunction

   // in place, so cells cleared earlier in the raster count as free
   function automatic void despeckle_cells();
      int nr, nc, zeros;
      logic signed [7:0] v;
      for (int r = 0; r < GH; r++) begin
         for (int c = 0; c < GW; c++) begin
            v = grid_cells[r*GW+c];
            if (v < 1 || v > 98) continue;
            zeros = 0;
            for (int dr = -3; dr <= 3; dr++) begin
               for (int dc = -3; dc <= 3; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if (nr < 0 || nr >= GH || nc < 0 || nc >= GW) continue;
                  if (grid_cells[nr*GW+nc] == 0) zeros++;
               end
            end
            if (zeros > int'(clear_limit)) grid_cells[r*GW+c] = 8'sd0;
         end
      end
   endfunction

   // updates the grid and returns 1 when the request yields a response
   function automatic bit predict_grid(logic [1:0] cmd, logic [13:0] idx, logic [7:0] val,
                                       logic full, output grid_rsp_t rsp);
      rsp = '0;
      case (cmd)
         CMD_WRITE: begin
            grid_cells[idx] = val;
            return 1'b0;
         end
         CMD_READ: begin
            rsp.kind = KIND_READ;
            rsp.value = grid_cells[idx];
            return 1'b1;
         end
         CMD_PROCESS: begin
            inflate_obstacles(full);
            despeckle_cells();
            rsp.kind = KIND_DONE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_request(logic [1:0] cmd, logic [13:0] idx, logic [7:0] val, logic full,
                               bit typed = 0, grid_rsp_t typed_rsp = '0);
      grid_rsp_t rsp;
      bit        has_rsp;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, full, val, idx, cmd};
      do @(posedge clock); while (!req_tready);
      has_rsp = predict_grid(cmd, idx, val, full, rsp);
      if (has_rsp) pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : rsp);
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // only while idle: every response in and the trailing write retired
   task automatic csr_write(logic index, logic [13:0] data);
      wait (pending_rsp.size() == 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_RADIUS) radius_sq = data;
      else clear_limit = data[5:0];
   endtask

   function automatic logic [7:0] pick_value();
      int roll = $urandom_range(99);
      if (roll < 30) return 8'd0;
      if (roll < 40) return 8'hFF;
      if (roll < 48) return OBSTACLE_VAL;
      if (roll < 53) return INFLATED_VAL;
      if (roll < 90) return 8'($urandom_range(98, 1));
      return 8'($urandom);
   endfunction

   task automatic random_requests(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(199);
         if (roll < 90) send_request(CMD_WRITE, 14'($urandom), pick_value(), 1'($urandom));
         else if (roll < 193)
            send_request(CMD_READ, 14'($urandom), 8'($urandom), 1'($urandom));
         else if (roll < 198)
            send_request(CMD_PROCESS, 14'($urandom), 8'($urandom), 1'($urandom));
         else send_request(CMD_UNUSED, 14'($urandom), 8'($urandom), 1'($urandom));
      end
      end_requests();
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle);

   always @(posedge clock) begin
      grid_rsp_t want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response kind %0d value %0d", rsp_tuser, $signed(rsp_tdata));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                           want.kind, $signed(want.value), rsp_tuser, $signed(rsp_tdata));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[occupancy_grid_inflate_and_despeckle] ERROR");
         $finish;
      end
   end

   localparam int CENTRE = (GH/2)*GW + GW/2;
   localparam grid_rsp_t DONE_RSP = '{kind: KIND_DONE, value: 8'd0};

   stim_row_t directed [] = '{
      '{CMD_WRITE,   14'd0,      8'h80,  1'b0, 0, '0},
      '{CMD_READ,    14'd0,      8'h00,  1'b0, 1, '{KIND_READ, 8'h80}},
      '{CMD_WRITE,   14'd16383,  8'h7F,  1'b1, 0, '0},
      '{CMD_READ,    14'd16383,  8'hFF,  1'b1, 1, '{KIND_READ, 8'h7F}},
      '{CMD_WRITE,   14'd0,      8'd100, 1'b0, 0, '0},
      '{CMD_WRITE,   14'd1,      8'd50,  1'b0, 0, '0},
      '{CMD_WRITE,   14'd130,    8'd0,   1'b0, 0, '0},
      '{CMD_UNUSED,  14'd5,      8'd7,   1'b1, 0, '0},
      '{CMD_READ,    14'd5,      8'd0,   1'b0, 0, '0},
      '{CMD_WRITE,   14'd16383,  8'hFF,  1'b0, 0, '0},
      '{CMD_PROCESS, 14'd0,      8'd0,   1'b0, 1, DONE_RSP},
      '{CMD_READ,    14'd1,      8'd0,   1'b0, 0, '0},
      '{CMD_READ,    14'd129,    8'd0,   1'b0, 0, '0},
      '{CMD_WRITE,   14'(CENTRE),   8'd100, 1'b0, 0, '0},
      '{CMD_WRITE,   14'(CENTRE+1), 8'd30,  1'b0, 0, '0},
      '{CMD_PROCESS, 14'd0,      8'd0,   1'b0, 1, DONE_RSP},
      '{CMD_READ,    14'(CENTRE+1), 8'd0, 1'b0, 0, '0},
      '{CMD_READ,    14'(CENTRE+2), 8'd0, 1'b0, 0, '0},
      '{CMD_PROCESS, 14'd0,      8'd0,   1'b1, 1, DONE_RSP},
      '{CMD_READ,    14'(CENTRE+2), 8'd0, 1'b0, 0, '0},
      '{CMD_WRITE,   14'(CENTRE),   8'd0,  1'b0, 0, '0},
      '{CMD_READ,    14'd16383,  8'd0,   1'b0, 0, '0},
      '{CMD_WRITE,   14'd300,    8'd101, 1'b0, 0, '0},
      '{CMD_READ,    14'd300,    8'd0,   1'b0, 1, '{KIND_READ, 8'd101}}
   };

   initial begin
      int roll;
      logic [7:0] bg;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the cell store has no reset, so every cell is loaded before any pass
      for (int i = 0; i < NCELLS; i++) begin
         roll = $urandom_range(999);
         bg = roll < 100 ? 8'hFF : roll < 102 ? OBSTACLE_VAL :
              roll < 107 ? 8'($urandom_range(98, 1)) : 8'd0;
         send_request(CMD_WRITE, 14'(i), bg, 1'b0);
      end

      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].idx, directed[i].val, directed[i].full,
                      directed[i].typed, directed[i].rsp);
      end_requests();

      csr_write(CSR_RADIUS, 14'd0);
      csr_write(CSR_THRESH, 14'd49);
      random_requests(210);

      sender_idle = 78;
      rx_idle = 15;
      csr_write(CSR_RADIUS, 14'd8192);
      csr_write(CSR_THRESH, 14'd0);
      random_requests(210);

      sender_idle = 0;
      rx_idle = 0;
      csr_write(CSR_RADIUS, 14'($urandom_range(3000, 200)));
      csr_write(CSR_THRESH, 14'($urandom_range(40, 20)));
      random_requests(210);

      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("[occupancy_grid_inflate_and_despeckle] OK");
      else
         $display("[occupancy_grid_inflate_and_despeckle] ERROR");
      $finish;
   end
endmodule

`default_nettype wire
